/* sv/bba_pkg.sv */
package bba_pkg;

   localparam int CMD_W = 1;
   localparam int REQ_W = 14;
   localparam int ADDR_W = 32;
   localparam int STATUS_W = 3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [2:0] ST_ABOVE_MAX = 3'd2;
   localparam logic [2:0] ST_BELOW_MIN = 3'd3;
   localparam logic [2:0] ST_ORDER_BIG = 3'd4;
   localparam logic [2:0] ST_NO_BLOCK = 3'd5;
   localparam logic [2:0] ST_BAD_FREE = 3'd6;

   localparam logic [2:0] REG_ORDER_LIMIT = 3'd0;
   localparam logic [2:0] REG_HEAP_BASE = 3'd1;
   localparam logic [2:0] REG_MAX_ON = 3'd2;
   localparam logic [2:0] REG_MAX_REQ = 3'd3;
   localparam logic [2:0] REG_MIN_ON = 3'd4;
   localparam logic [2:0] REG_MIN_REQ = 3'd5;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_CLEAR    = 12'b000000000010,
      S_CHECK    = 12'b000000000100,
      S_SIZE     = 12'b000000001000,
      S_SCAN     = 12'b000000010000,
      S_SCAN_RD  = 12'b000000100000,
      S_SPLIT    = 12'b000001000000,
      S_FREE_CHK = 12'b000010000000,
      S_FREE_RD  = 12'b000100000000,
      S_MERGE    = 12'b001000000000,
      S_MERGE_RD = 12'b010000000000,
      S_DONE     = 12'b100000000000
   } state_type;

endpackage

/* sv/bba_map.sv */
module bba_map #(
   parameter int DEPTH = 511,
   parameter int AW = 9,
   parameter int W = 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/buddy_block_allocator.sv */
// Binary buddy allocator. Each item is an allocate or a free command and
// gives exactly one result item. A small sequencer steps through the
// orders: an allocate first scans the free map block by block from the
// requested order upward (one map read per block), then splits down one
// order per cycle; a free merges one order per pass through S_MERGE and
// S_MERGE_RD. After reset, and after a write of order_limit while idle, a
// clearing pass wipes both maps, and no item is accepted meanwhile.
module buddy_block_allocator #(
   parameter int MIN_BLOCK_BYTES = 32,
   parameter int HEAP_ORDER = 8,
   parameter int HEADER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // command, request_bytes, free_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // block_address, status
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int UNITS = 1 << HEAP_ORDER;
   localparam int MAP_SIZE = (1 << (HEAP_ORDER + 1)) - 1;
   localparam int MAW = HEAP_ORDER + 1;
   localparam int UW = (HEAP_ORDER > 0) ? HEAP_ORDER : 1;
   localparam int OW = 5;
   localparam int MB_SH = $clog2(MIN_BLOCK_BYTES);
   localparam logic [OW-1:0] MAXO = OW'(HEAP_ORDER);

   bba_pkg::state_type state_ff, state_in;

   logic [3:0] order_limit_ff;
   logic [31:0] heap_base_ff;
   logic max_on_ff, min_on_ff;
   logic [13:0] max_req_ff, min_req_ff;

   logic cmd_ff;
   logic [13:0] size_ff;
   logic [31:0] faddr_ff;
   logic [OW-1:0] k_ff, k_in, j_ff, j_in, lim;
   logic [UW:0] idx_ff, idx_in;
   logic [UW-1:0] unit_ff, unit_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic [2:0] out_st_ff, out_st_in;
   logic [UW:0] clr_ff, clr_in;

   logic fm_we, go_we;
   logic [MAW-1:0] fm_wa, fm_ra;
   logic fm_wd, fm_rd;
   logic [UW-1:0] go_wa, go_ra;
   logic [OW-1:0] go_wd, go_rd;

   bba_map #(.DEPTH(MAP_SIZE), .AW(MAW), .W(1)) u_free (
      .clock(clock), .wr_en(fm_we), .wr_addr(fm_wa), .wr_data(fm_wd),
      .rd_addr(fm_ra), .rd_data(fm_rd));
   bba_map #(.DEPTH(UNITS), .AW(UW), .W(OW)) u_grant (
      .clock(clock), .wr_en(go_we), .wr_addr(go_wa), .wr_data(go_wd),
      .rd_addr(go_ra), .rd_data(go_rd));

   function automatic logic [MAW-1:0] slot(input logic [OW-1:0] k, input logic [UW:0] idx);
      logic [MAW+1:0] base;
      logic [MAW+1:0] pos;
      base = (MAW+2)'(1) << MAW;
      base = base - (((MAW+2)'(1) << MAW) >> k);
      pos = base + ((MAW+2)'(idx) & ((((MAW+2)'(1) << HEAP_ORDER) >> k) - 1'b1));
      slot = (pos < (MAW+2)'(MAP_SIZE)) ? pos[MAW-1:0] : '0;
   endfunction

   assign lim = (OW'(order_limit_ff) > MAXO) ? MAXO : OW'(order_limit_ff);

   logic [32:0] rel;
   logic [UW+1:0] scan_n;
   assign rel = {1'b0, faddr_ff - heap_base_ff - 32'(HEADER_BYTES)};
   assign scan_n = (UW+2)'(1) << (lim - j_ff);

   always_comb begin
      state_in = state_ff;
      k_in = k_ff; j_in = j_ff; idx_in = idx_ff; unit_in = unit_ff;
      out_addr_in = out_addr_ff; out_st_in = out_st_ff; clr_in = clr_ff;
      fm_we = 1'b0; fm_wa = slot(j_ff, idx_ff); fm_wd = 1'b0; fm_ra = slot(j_ff, idx_ff);
      go_we = 1'b0; go_wa = unit_ff; go_wd = '0; go_ra = unit_ff;
      case (state_ff)
         bba_pkg::S_IDLE: begin
            if (csr_wr_en && csr_index == bba_pkg::REG_ORDER_LIMIT) begin
               clr_in = '0;
               state_in = bba_pkg::S_CLEAR;
            end else if (req_tvalid) begin
               out_addr_in = '0;
               out_st_in = bba_pkg::ST_OK;
               state_in = (req_tdata[0] == bba_pkg::CMD_FREE) ?
                  bba_pkg::S_FREE_CHK : bba_pkg::S_CHECK;
            end
         end
         bba_pkg::S_CLEAR: begin
            fm_we = 1'b1;
            fm_wa = MAW'(clr_ff);
            go_we = 1'b1;
            go_wa = clr_ff[UW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (UW+1)'(MAP_SIZE - 1)) begin
               state_in = bba_pkg::S_SPLIT;
               j_in = lim; k_in = lim; idx_in = '0;
            end
         end
         bba_pkg::S_CHECK: begin
            k_in = '0;
            if (size_ff == '0) begin
               out_st_in = bba_pkg::ST_ZERO_SIZE; state_in = bba_pkg::S_DONE;
            end else if (max_on_ff && size_ff > max_req_ff) begin
               out_st_in = bba_pkg::ST_ABOVE_MAX; state_in = bba_pkg::S_DONE;
            end else if (min_on_ff && size_ff < min_req_ff) begin
               out_st_in = bba_pkg::ST_BELOW_MIN; state_in = bba_pkg::S_DONE;
            end else begin
               state_in = bba_pkg::S_SIZE;
            end
         end
         bba_pkg::S_SIZE: begin
            if ((64'(MIN_BLOCK_BYTES) << k_ff) < 64'(size_ff) + 64'(HEADER_BYTES)
                && k_ff <= MAXO) begin
               k_in = k_ff + 1'b1;
            end else if (k_ff > lim) begin
               out_st_in = bba_pkg::ST_ORDER_BIG; state_in = bba_pkg::S_DONE;
            end else begin
               j_in = k_ff; idx_in = '0; state_in = bba_pkg::S_SCAN;
            end
         end
         bba_pkg::S_SCAN: begin
            state_in = bba_pkg::S_SCAN_RD;
         end
         bba_pkg::S_SCAN_RD: begin
            if (fm_rd) begin
               fm_we = 1'b1;
               state_in = bba_pkg::S_SPLIT;
            end else if ((UW+2)'(idx_ff) + 1'b1 < scan_n) begin
               idx_in = idx_ff + 1'b1; state_in = bba_pkg::S_SCAN;
            end else if (j_ff < lim) begin
               j_in = j_ff + 1'b1; idx_in = '0; state_in = bba_pkg::S_SCAN;
            end else begin
               out_st_in = bba_pkg::ST_NO_BLOCK; state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_SPLIT: begin
            if (cmd_ff == bba_pkg::CMD_ALLOC || j_ff > k_ff) begin
               if (j_ff > k_ff) begin
                  j_in = j_ff - 1'b1;
                  idx_in = idx_ff << 1;
                  fm_we = 1'b1; fm_wd = 1'b1;
                  fm_wa = slot(j_ff - 1'b1, (idx_ff << 1) + 1'b1);
               end else begin
                  unit_in = UW'(idx_ff << k_ff);
                  go_we = 1'b1; go_wa = UW'(idx_ff << k_ff); go_wd = k_ff + 1'b1;
                  out_addr_in = heap_base_ff + 32'((32'(UW'(idx_ff << k_ff))) << MB_SH)
                                + 32'(HEADER_BYTES);
                  state_in = bba_pkg::S_DONE;
               end
            end else begin
               fm_we = 1'b1; fm_wd = 1'b1; fm_wa = slot(j_ff, '0);
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_FREE_CHK: begin
            if (rel >= (33'(MIN_BLOCK_BYTES) << lim) || rel[MB_SH-1:0] != '0) begin
               out_st_in = bba_pkg::ST_BAD_FREE; state_in = bba_pkg::S_DONE;
            end else begin
               unit_in = UW'(rel >> MB_SH);
               go_ra = UW'(rel >> MB_SH);
               state_in = bba_pkg::S_FREE_RD;
            end
         end
         bba_pkg::S_FREE_RD: begin
            if (go_rd == '0 || go_rd - 1'b1 > lim) begin
               out_st_in = bba_pkg::ST_BAD_FREE; state_in = bba_pkg::S_DONE;
            end else begin
               go_we = 1'b1;
               k_in = go_rd - 1'b1;
               idx_in = (UW+1)'(unit_ff) >> (go_rd - 1'b1);
               state_in = bba_pkg::S_MERGE;
            end
         end
         bba_pkg::S_MERGE: begin
            fm_ra = slot(k_ff, idx_ff ^ 1'b1);
            if (k_ff < lim) begin
               state_in = bba_pkg::S_MERGE_RD;
            end else begin
               fm_we = 1'b1; fm_wd = 1'b1; fm_wa = slot(k_ff, idx_ff);
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_MERGE_RD: begin
            if (fm_rd) begin
               fm_we = 1'b1; fm_wa = slot(k_ff, idx_ff ^ 1'b1);
               idx_in = idx_ff >> 1; k_in = k_ff + 1'b1;
               state_in = bba_pkg::S_MERGE;
            end else begin
               fm_we = 1'b1; fm_wd = 1'b1; fm_wa = slot(k_ff, idx_ff);
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_DONE: begin
            if (rsp_tready) state_in = bba_pkg::S_IDLE;
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
         clr_ff <= '0;
         order_limit_ff <= 4'd8;
         heap_base_ff <= '0;
         max_on_ff <= 1'b0;
         max_req_ff <= 14'd8192;
         min_on_ff <= 1'b0;
         min_req_ff <= '0;
         cmd_ff <= bba_pkg::CMD_ALLOC;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (state_ff == bba_pkg::S_CLEAR) cmd_ff <= bba_pkg::CMD_FREE;
         if (req_tvalid && req_tready) cmd_ff <= req_tdata[0];
         if (csr_wr_en) begin
            case (csr_index)
               bba_pkg::REG_ORDER_LIMIT: order_limit_ff <= csr_data[3:0];
               bba_pkg::REG_HEAP_BASE: heap_base_ff <= csr_data;
               bba_pkg::REG_MAX_ON: max_on_ff <= csr_data[0];
               bba_pkg::REG_MAX_REQ: max_req_ff <= csr_data[13:0];
               bba_pkg::REG_MIN_ON: min_on_ff <= csr_data[0];
               bba_pkg::REG_MIN_REQ: min_req_ff <= csr_data[13:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; j_ff <= j_in; idx_ff <= idx_in; unit_ff <= unit_in;
      out_addr_ff <= out_addr_in; out_st_ff <= out_st_in;
      if (req_tvalid && req_tready) begin
         size_ff <= req_tdata[14:1];
         faddr_ff <= req_tdata[46:15];
      end
   end

   assign req_tready = (state_ff == bba_pkg::S_IDLE) &&
      !(csr_wr_en && csr_index == bba_pkg::REG_ORDER_LIMIT);
   assign rsp_tvalid = (state_ff == bba_pkg::S_DONE);
   assign rsp_tdata = {5'b0, out_st_ff, out_addr_ff};

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_st_ff != bba_pkg::ST_OK |-> out_addr_ff == '0)
      else $error("failed result carries an address");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("accept while result pending");

endmodule
